// ===== rtl/itaf_pkg.sv =====
package itaf_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FW_W = 6;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W = NUM_DIGITS * DIG_W;
  localparam int unsigned NDIG_W = 4;
  localparam int unsigned RESULT_LIMIT = 32;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [DIG_W-1:0] DEC_RADIX = 4'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hex_base;
    logic               signed_mode;
    logic [FW_W-1:0]    field_width;
    logic [1:0]         pad_mode;
    logic               upper_case;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [CNT_W-1:0]  total_count;
  } out_word_t;

  // format info handed from converter to emitter
  typedef struct packed {
    logic              neg;
    logic              left;
    logic              zfill;
    logic              upper;
    logic [FW_W-1:0]   width;
    logic [NDIG_W-1:0] ndig;
  } fmt_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base_c;
    base_c = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DEC_RADIX) begin
      digit_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      digit_char = base_c + CHAR_W'(d - DEC_RADIX);
    end
  endfunction

endpackage

// ===== rtl/itaf_conv.sv =====
module itaf_conv
  import itaf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  input  logic [FW_W-1:0]       width_i,
  output logic                  dig_valid_o,
  input  logic                  dig_ready_i,
  output fmt_t                  fmt_o,
  output logic [BCD_W-1:0]      digits_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               hex_q, hex_d;
  fmt_t               fmt_q, fmt_d;
  logic               neg;
  logic [BCD_W-1:0]   bcd_adj;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (r[i*DIG_W +: DIG_W] >= 4'd5) begin
        r[i*DIG_W +: DIG_W] = r[i*DIG_W +: DIG_W] + 4'd3;
      end
    end
    return r;
  endfunction

  assign neg = in_data_i.signed_mode & ~in_data_i.hex_base & in_data_i.value[VALUE_W-1];
  assign bcd_adj = hex_q ? bcd_q : dabble(bcd_q);

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    hex_d   = hex_q;
    fmt_d   = fmt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d       = neg ? (~in_data_i.value + VALUE_W'(1)) : in_data_i.value;
          bcd_d       = '0;
          cnt_d       = CNT_W'(VALUE_W);
          hex_d       = in_data_i.hex_base;
          fmt_d.neg   = neg;
          fmt_d.left  = in_data_i.pad_mode[0];
          fmt_d.zfill = in_data_i.pad_mode[1];
          fmt_d.upper = in_data_i.upper_case;
          fmt_d.width = width_i;
          fmt_d.ndig  = NDIG_W'(NUM_DIGITS);
          state_d     = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (bcd_q[BCD_W-1 -: DIG_W] == '0 && fmt_q.ndig > NDIG_W'(1)) begin
          bcd_d      = {bcd_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          fmt_d.ndig = fmt_q.ndig - NDIG_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (dig_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    hex_q <= hex_d;
    fmt_q <= fmt_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign dig_valid_o = (state_q == ST_DONE);
  assign fmt_o       = fmt_q;
  assign digits_o    = bcd_q;

endmodule

// ===== rtl/itaf_emit.sv =====
module itaf_emit
  import itaf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dig_valid_i,
  output logic             dig_ready_o,
  input  fmt_t             fmt_i,
  input  logic [BCD_W-1:0] digits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_data_o
);

  logic              busy_q;
  logic              sgn1_q, sgn2_q;
  logic [FW_W-1:0]   lpad_q, rpad_q;
  logic [NDIG_W-1:0] dcnt_q;
  logic [BCD_W-1:0]  dig_q;
  logic [CNT_W-1:0]  rem_q, total_q;
  logic [CHAR_W-1:0] fill_q;
  logic              upper_q;
  logic              ovalid_q;
  out_word_t         odata_q;

  logic              load, adv;
  logic              sign_first;
  logic [FW_W-1:0]   w2, tlen, pad;
  logic [CHAR_W-1:0] ch;

  assign load = dig_valid_i & ~busy_q;
  assign adv  = busy_q & (~ovalid_q | out_ready_i);
  assign dig_ready_o = ~busy_q;

  assign sign_first = fmt_i.neg & (fmt_i.width != '0) & fmt_i.zfill;
  assign w2   = fmt_i.width - FW_W'(sign_first);
  assign tlen = FW_W'(fmt_i.ndig) + FW_W'(fmt_i.neg & ~sign_first);
  assign pad  = (tlen >= w2) ? '0 : (w2 - tlen);

  always_comb begin
    priority if (sgn1_q) begin
      ch = CHAR_MINUS;
    end else if (lpad_q != '0) begin
      ch = fill_q;
    end else if (sgn2_q) begin
      ch = CHAR_MINUS;
    end else if (dcnt_q != '0) begin
      ch = digit_char(dig_q[BCD_W-1 -: DIG_W], upper_q);
    end else begin
      ch = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (adv && rem_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sgn1_q  <= sign_first;
      sgn2_q  <= fmt_i.neg & ~sign_first;
      lpad_q  <= fmt_i.left ? '0 : pad;
      rpad_q  <= fmt_i.left ? pad : '0;
      dcnt_q  <= fmt_i.ndig;
      dig_q   <= digits_i;
      rem_q   <= CNT_W'(sign_first) + pad + tlen;
      total_q <= CNT_W'(sign_first) + pad + tlen;
      fill_q  <= fmt_i.zfill ? CHAR_ZERO : CHAR_SPACE;
      upper_q <= fmt_i.upper;
    end else if (adv) begin
      rem_q <= rem_q - CNT_W'(1);
      priority if (sgn1_q) begin
        sgn1_q <= 1'b0;
      end else if (lpad_q != '0) begin
        lpad_q <= lpad_q - FW_W'(1);
      end else if (sgn2_q) begin
        sgn2_q <= 1'b0;
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - NDIG_W'(1);
        dig_q  <= {dig_q[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
      end else begin
        rpad_q <= rpad_q - FW_W'(1);
      end
    end
    if (adv) begin
      odata_q.character   <= ch;
      odata_q.last        <= (rem_q == CNT_W'(1));
      odata_q.total_count <= (rem_q == CNT_W'(1)) ? total_q : '0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// Conversion: 32 bit-shift steps of binary to digit conversion, up to 9 steps
// stripping leading zero digits, then the emitter sends one character per
// cycle while the output is not stalled (1 to 32 chars).
// Overlap: a run of up to 32 characters overlaps the next conversion, so a new
// word is taken during a run and only output stalls make a run outlast it.
// Reset: rst_ni asynchronous active low clears all control state.
module integer_to_ascii_formatter_unit
  import itaf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned CapWidth = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;
  localparam logic [FW_W-1:0] CAP_W = FW_W'(CapWidth);

  logic [FW_W-1:0]  width;
  logic             dig_valid, dig_ready;
  fmt_t             fmt;
  logic [BCD_W-1:0] digits;

  assign width = (in_data_i.field_width > CAP_W) ? CAP_W : in_data_i.field_width;

  itaf_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .width_i     (width),
    .dig_valid_o (dig_valid),
    .dig_ready_i (dig_ready),
    .fmt_o       (fmt),
    .digits_o    (digits)
  );

  itaf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dig_valid_i (dig_valid),
    .dig_ready_o (dig_ready),
    .fmt_i       (fmt),
    .digits_i    (digits),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
